// ===== hw/rtl/ptli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptli_pkg
// Shared constants and types for the periodic table interpolator.
// ----------------------------------------------------------------------------
package ptli_pkg;

  localparam int MAX_ACT    = 8;
  localparam int ACT_W      = 3;
  localparam int TAB_DEPTH  = 128;
  localparam int ENTRY_W    = 7;
  localparam int FRAC_BITS  = 16;
  localparam int ADDR_W     = ACT_W + ENTRY_W;
  localparam int RAM_DEPTH  = MAX_ACT * TAB_DEPTH;
  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int N_W        = 8;
  localparam int CNT_W      = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;
  localparam int STEP_W     = 6;
  localparam int SCALED_W   = TIME_W + ENTRY_W;
  localparam int QUOT_W     = ENTRY_W + FRAC_BITS;

  localparam logic [STEP_W-1:0] DIV1_STEPS = STEP_W'(TIME_W);
  localparam logic [STEP_W-1:0] DIV2_STEPS = STEP_W'(QUOT_W);

  localparam logic [TIME_W-1:0] RESET_CYCLE_LEN = TIME_W'(5000000);
  localparam logic [N_W-1:0]    RESET_ENTRIES   = N_W'(100);
  localparam logic [CNT_W-1:0]  RESET_ACTIVE    = CNT_W'(MAX_ACT);

  // input transaction kinds
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIME    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd2;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [TIME_W-1:0] rem_init;
    logic [TIME_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quot;
    logic [TIME_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/periodic_table_linear_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_table_linear_interp
// Per-actuator periodic waveform player with linear table interpolation.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake            Payload
// in_*      in    in_valid/in_ready    kind, actuator, entry, sample, time_now
// out_*     out   out_valid/out_ready  channel, drive, last
// cfg_*     in    cfg_we               cfg_index, cfg_wdata (no read-back)
//
// Write and restart transactions complete on acceptance.
// A time transaction holds in_ready low until it is done: a 32-step remainder
// division (skipped when the time lies before the anchor) and a 23-step
// position/fraction division share one serial divider, each reporting done
// when finished, then each of the N active actuators needs two reads of the
// single-read-port table, a multiply and an output load.
// After reset a clearing pass zeroes the 1024-entry table;
// in_ready stays low meanwhile, config writes are taken.
// A stalled output holds its register; the next input is taken as soon as
// the current time transaction has loaded its last result.
// ----------------------------------------------------------------------------
module periodic_table_linear_interp (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ptli_pkg::KIND_W-1:0]         in_kind,
  input  logic [ptli_pkg::ACT_W-1:0]          in_actuator,
  input  logic [ptli_pkg::ENTRY_W-1:0]        in_entry,
  input  logic signed [ptli_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [ptli_pkg::TIME_W-1:0]         in_time_now,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ptli_pkg::ACT_W-1:0]          out_channel,
  output logic signed [ptli_pkg::SAMPLE_W-1:0] out_drive,
  output logic                                out_last,
  // configuration
  input  logic                                cfg_we,
  input  logic [ptli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptli_pkg::CFG_W-1:0]          cfg_wdata
);
  import ptli_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_START = 11'b000_0000_0100,
    S_DIV1  = 11'b000_0000_1000,
    S_SCALE = 11'b000_0001_0000,
    S_DIV2S = 11'b000_0010_0000,
    S_DIV2  = 11'b000_0100_0000,
    S_RDA   = 11'b000_1000_0000,
    S_RDB   = 11'b001_0000_0000,
    S_MUL   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [TIME_W-1:0] cycle_len_r;
  logic [N_W-1:0]    entries_r;
  logic [CNT_W-1:0]  active_r;

  // anchor state
  logic [TIME_W-1:0] cycle_start_r;
  logic              anchored_r;

  // control
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ACT_W-1:0]  act_r;

  // datapath
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   elapsed_r;
  logic [TIME_W-1:0]   phase_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [ENTRY_W-1:0]  a_r;
  logic [ENTRY_W-1:0]  b_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [SAMPLE_W-1:0] ya_r;
  logic signed [SAMPLE_W+FRAC_BITS+1:0] prod_r;

  // output register
  logic                out_valid_r;
  logic [ACT_W-1:0]    out_channel_r;
  logic [SAMPLE_W-1:0] out_drive_r;
  logic                out_last_r;

  // derived values
  logic [TIME_W-1:0]   len_eff;
  logic [N_W-1:0]      n_eff;
  logic [CNT_W-1:0]    cnt_eff;
  logic                in_acc;
  logic                out_free;
  logic                last_act;
  logic [TIME_W+N_W-1:0] scaled_full;
  logic [ENTRY_W-1:0]  a_raw;
  logic [ENTRY_W-1:0]  a_cl;
  logic [ENTRY_W-1:0]  b_cl;
  logic signed [SAMPLE_W:0] dy;
  logic signed [SAMPLE_W+FRAC_BITS+1:0] prod_nxt;
  logic [SAMPLE_W+1:0] drive_sum;

  // memory ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // Effective configuration: zero length acts as one, entry and actuator
  // counts are clamped to the table geometry.
  // --------------------------------------------------------------------------
  assign len_eff = (cycle_len_r == '0) ? TIME_W'(1) : cycle_len_r;

  always_comb begin
    n_eff = entries_r;
    if (entries_r < N_W'(2)) begin
      n_eff = N_W'(2);
    end else if (entries_r > N_W'(TAB_DEPTH)) begin
      n_eff = N_W'(TAB_DEPTH);
    end
  end

  always_comb begin
    cnt_eff = active_r;
    if (active_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (active_r > CNT_W'(MAX_ACT)) begin
      cnt_eff = CNT_W'(MAX_ACT);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last_act = ({1'b0, act_r} == (cnt_eff - CNT_W'(1)));

  // --------------------------------------------------------------------------
  // Position arithmetic.
  // scaled = phase * n. The divider then yields floor(scaled * 2^FRAC / len),
  // whose upper bits are the table index and lower bits the fraction. Since
  // scaled < n * len, the bits above the quotient already sit below len and
  // seed the remainder.
  // --------------------------------------------------------------------------
  assign scaled_full = {{N_W{1'b0}}, phase_r} * {{TIME_W{1'b0}}, n_eff};

  assign a_raw = div_rsp.quot[QUOT_W-1:FRAC_BITS];
  assign a_cl  = ({1'b0, a_raw} >= n_eff) ? ENTRY_W'(n_eff - N_W'(1)) : a_raw;
  // wrap neighbor: entry after the last used one is entry zero
  assign b_cl  = (({1'b0, a_cl} + N_W'(1)) == n_eff) ? '0 : a_cl + ENTRY_W'(1);

  // interpolation: ya + floor((yb - ya) * frac / 2^FRAC)
  assign dy       = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                  - $signed({ya_r[SAMPLE_W-1], ya_r});
  // 17x17 signed product, operands extended to the full product width
  assign prod_nxt = $signed({{(FRAC_BITS+1){dy[SAMPLE_W]}}, dy})
                  * $signed({{(SAMPLE_W+2){1'b0}}, frac_r});
  assign drive_sum = {{2{ya_r[SAMPLE_W-1]}}, ya_r}
                   + prod_r[SAMPLE_W+FRAC_BITS+1:FRAC_BITS];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    div_req          = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_kind == KIND_TIME) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        // time before anchor: phase zero, skip the remainder division
        if (now_r >= cycle_start_r) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV1_STEPS;
          div_req.rem_init = '0;
          div_req.num      = now_r - cycle_start_r;
          state_nxt        = S_DIV1;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        state_nxt = S_DIV2S;
      end
      S_DIV2S: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV2_STEPS;
        div_req.rem_init = scaled_r[SCALED_W-1:ENTRY_W];
        div_req.num      = {scaled_r[ENTRY_W-1:0], {(TIME_W-ENTRY_W){1'b0}}};
        state_nxt        = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        state_nxt = S_RDB;
      end
      S_RDB: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = last_act ? S_IDLE : S_RDA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      cycle_len_r   <= RESET_CYCLE_LEN;
      entries_r     <= RESET_ENTRIES;
      active_r      <= RESET_ACTIVE;
      cycle_start_r <= '0;
      anchored_r    <= 1'b0;
      act_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_CYCLE_LEN: cycle_len_r <= cfg_wdata[TIME_W-1:0];
          CFG_ENTRIES:   entries_r   <= cfg_wdata[N_W-1:0];
          CFG_ACTIVE:    active_r    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end

      // anchor: set by the first time transaction, cleared by restart,
      // advanced by whole cycles once the remainder is known
      if (in_acc && in_kind == KIND_TIME && !anchored_r) begin
        cycle_start_r <= in_time_now;
        anchored_r    <= 1'b1;
      end else if (in_acc && in_kind == KIND_RESTART) begin
        cycle_start_r <= '0;
        anchored_r    <= 1'b0;
      end else if (state_r == S_DIV1 && div_rsp.done) begin
        cycle_start_r <= cycle_start_r + (elapsed_r - div_rsp.rem);
      end

      if (state_r == S_DIV2 && div_rsp.done) begin
        act_r <= '0;
      end else if (state_r == S_OUT && out_free && !last_act) begin
        act_r <= act_r + ACT_W'(1);
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_time_now;
    end
    if (state_r == S_START) begin
      elapsed_r <= now_r - cycle_start_r;
      phase_r   <= '0;
    end
    if (state_r == S_DIV1 && div_rsp.done) begin
      phase_r <= div_rsp.rem;
    end
    if (state_r == S_SCALE) begin
      scaled_r <= scaled_full[SCALED_W-1:0];
    end
    if (state_r == S_DIV2 && div_rsp.done) begin
      a_r    <= a_cl;
      b_r    <= b_cl;
      frac_r <= div_rsp.quot[FRAC_BITS-1:0];
    end
    if (state_r == S_RDB) begin
      ya_r <= ram_rdata;
    end
    if (state_r == S_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      out_channel_r <= act_r;
      out_drive_r   <= drive_sum[SAMPLE_W-1:0];
      out_last_r    <= last_act;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_drive   = out_drive_r;
  assign out_last    = out_last_r;

  // --------------------------------------------------------------------------
  // Table memory. Writes happen only in the clearing pass or while idle and
  // reads only while a time transaction runs, so they never overlap.
  // --------------------------------------------------------------------------
  assign ram_we    = (state_r == S_CLEAR) || (in_acc && in_kind == KIND_WRITE);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : {in_actuator, in_entry};
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : in_sample;
  assign ram_raddr = (state_r == S_RDB) ? {act_r, b_r} : {act_r, a_r};

  ptli_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptli_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (len_eff),
    .rsp     (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_IDLE))
    else $error("table write while a time transaction reads the table");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a division state");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDA |-> ({1'b0, a_r} < n_eff && {1'b0, b_r} < n_eff))
    else $error("table index beyond used entries");

  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ({1'b0, out_channel_r} == cnt_eff - CNT_W'(1)))
    else $error("last flag on wrong channel");

  a_phase_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCALE |-> (phase_r < len_eff))
    else $error("phase not reduced below cycle length");

endmodule
`default_nettype wire

// ===== hw/rtl/ptli_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptli_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptli_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptli_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptli_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptli_pkg::div_req_t        req,
  input  logic [ptli_pkg::TIME_W-1:0] divisor,
  output ptli_pkg::div_rsp_t        rsp
);
  import ptli_pkg::*;

  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] num_r;
  logic [TIME_W-1:0] quot_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [TIME_W+1:0] diff;
  logic              ge;

  // rem_r < divisor always holds, so the trial fits in TIME_W+1 bits
  assign diff = {1'b0, rem_r, num_r[TIME_W-1]} - {2'b00, divisor};
  assign ge   = ~diff[TIME_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem_init;
      num_r  <= req.num;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[TIME_W-1:0] : {rem_r[TIME_W-2:0], num_r[TIME_W-1]};
      num_r  <= {num_r[TIME_W-2:0], 1'b0};
      quot_r <= {quot_r[TIME_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== tb/ptli_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptli_drive_checker
// Watches the table, time and config traffic of the interpolator, works out
// the drive values each time transaction must produce and compares them with
// the result channel in order.
// ----------------------------------------------------------------------------
module ptli_drive_checker
  import ptli_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [ACT_W-1:0]           in_actuator,
  input  logic [ENTRY_W-1:0]         in_entry,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [TIME_W-1:0]          in_time_now,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ACT_W-1:0]           out_channel,
  input  logic signed [SAMPLE_W-1:0] out_drive,
  input  logic                       out_last,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output int                         fail_count,
  output int                         pending
);

  typedef struct {
    logic [ACT_W-1:0]           channel;
    logic signed [SAMPLE_W-1:0] drive;
    logic                       last;
  } drive_t;

  drive_t drives_due[$];

  logic signed [SAMPLE_W-1:0] wave_mem [0:MAX_ACT-1][0:TAB_DEPTH-1];
  logic [TIME_W-1:0] anchor;
  logic              anchored;
  logic [TIME_W-1:0] cycle_len;
  logic [N_W-1:0]    entries_used;
  logic [CNT_W-1:0]  active_cnt;
  int                mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // one drive value per active actuator, interpolated at the current phase
  task automatic predict_drives(input logic [TIME_W-1:0] now);
    longint unsigned span, n_used, phase, elapsed, scaled, pos, frac, nxt;
    longint          ya, yb, wt;
    int              count;
    drive_t          r;
    span   = (cycle_len == '0) ? 1 : cycle_len;
    n_used = entries_used;
    if (n_used < 2) n_used = 2;
    if (n_used > TAB_DEPTH) n_used = TAB_DEPTH;
    count = active_cnt;
    if (count < 1) count = 1;
    if (count > MAX_ACT) count = MAX_ACT;
    if (!anchored) begin
      anchor   = now;
      anchored = 1'b1;
    end
    phase = 0;
    if (now >= anchor) begin
      elapsed = now - anchor;
      phase   = elapsed % span;
      anchor  = anchor + TIME_W'(elapsed - phase);
    end
    scaled = phase * n_used;
    pos    = scaled / span;
    frac   = ((scaled % span) << FRAC_BITS) / span;
    if (pos >= n_used) pos = n_used - 1;
    nxt = (pos + 1 == n_used) ? 0 : pos + 1;
    wt  = frac;
    for (int i = 0; i < count; i++) begin
      ya = wave_mem[i][pos];
      yb = wave_mem[i][nxt];
      r.channel = ACT_W'(i);
      r.drive   = SAMPLE_W'(ya + (((yb - ya) * wt) >>> FRAC_BITS));
      r.last    = (i + 1 == count);
      drives_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      for (int a = 0; a < MAX_ACT; a++)
        for (int e = 0; e < TAB_DEPTH; e++)
          wave_mem[a][e] = '0;
      anchor       = '0;
      anchored     = 1'b0;
      cycle_len    = RESET_CYCLE_LEN;
      entries_used = RESET_ENTRIES;
      active_cnt   = RESET_ACTIVE;
      drives_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CYCLE_LEN: cycle_len    = cfg_wdata[TIME_W-1:0];
          CFG_ENTRIES:   entries_used = cfg_wdata[N_W-1:0];
          CFG_ACTIVE:    active_cnt   = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drives_due.size() == 0) begin
          report_mismatch("result with none pending, channel", out_channel, -1);
        end else begin
          want = drives_due.pop_front();
          if (out_channel !== want.channel)
            report_mismatch("channel", out_channel, want.channel);
          if (out_drive !== want.drive)
            report_mismatch($sformatf("drive on channel %0d", want.channel),
                            out_drive, want.drive);
          if (out_last !== want.last)
            report_mismatch($sformatf("last on channel %0d", want.channel),
                            out_last, want.last);
        end
      end
      if (in_valid && in_ready) begin
        case (in_kind)
          KIND_WRITE:   wave_mem[in_actuator][in_entry] = in_sample;
          KIND_TIME:    predict_drives(in_time_now);
          KIND_RESTART: begin
            anchor   = '0;
            anchored = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending    <= drives_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_periodic_table_linear_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_table_linear_interp
// Drives table writes, time samples and restarts into the interpolator under
// several cycle/table/actuator settings, with random stalls on both channels
// (none in the last settings); a side checker predicts every drive value and compares them in order.
// ----------------------------------------------------------------------------
module tb_periodic_table_linear_interp;
  import ptli_pkg::*;

  // kind value the block must ignore
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [KIND_W-1:0]          in_kind;
  logic [ACT_W-1:0]           in_actuator;
  logic [ENTRY_W-1:0]         in_entry;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [TIME_W-1:0]          in_time_now;
  logic                       out_valid;
  logic                       out_ready;
  logic [ACT_W-1:0]           out_channel;
  logic signed [SAMPLE_W-1:0] out_drive;
  logic                       out_last;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  int fail_count;
  int pending;

  // idle odds per cycle, in percent
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // what the stimulus knows of the current settings
  logic [TIME_W-1:0] cur_span;
  int unsigned       cur_n;
  logic [TIME_W-1:0] tick;

  periodic_table_linear_interp dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_actuator (in_actuator),
    .in_entry    (in_entry),
    .in_sample   (in_sample),
    .in_time_now (in_time_now),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_drive   (out_drive),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  ptli_drive_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_actuator (in_actuator),
    .in_entry    (in_entry),
    .in_sample   (in_sample),
    .in_time_now (in_time_now),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_drive   (out_drive),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop; the slowest legal run is a small fraction of this
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Drop valid, let every pending result drain, then give the block time to
  // finish a write or restart that produced nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // one register write per cycle; caller lowers cfg_we after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Upper bits of the narrow registers carry junk the block must drop;
  // the spare index gets a write that must change nothing.
  task automatic apply_settings(input logic [TIME_W-1:0] len, input logic [N_W-1:0] n,
                                input logic [CNT_W-1:0] cnt);
    logic [CFG_W-1:0] junk;
    junk = $urandom;
    wait_idle();
    write_reg(CFG_CYCLE_LEN, len);
    write_reg(CFG_ENTRIES, {junk[CFG_W-1:N_W], n});
    write_reg(CFG_ACTIVE, {junk[CFG_W-1:CNT_W], cnt});
    write_reg(CFG_SPARE, $urandom);
    cfg_we   <= 1'b0;
    cur_span = len;
    cur_n    = (n < 2) ? 2 : (n > TAB_DEPTH) ? TAB_DEPTH : n;
  endtask

  // Called on a rising edge; returns on the edge that takes the transaction.
  // Valid stays high into the next transaction unless a gap is drawn.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ACT_W-1:0] act,
                           input logic [ENTRY_W-1:0] ent, input logic [SAMPLE_W-1:0] smp,
                           input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_actuator <= act;
    in_entry    <= ent;
    in_sample   <= smp;
    in_time_now <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  // unused fields of time and write transactions carry random bits
  task automatic send_time(input logic [TIME_W-1:0] now);
    send_item(KIND_TIME, $urandom, $urandom, $urandom, now);
  endtask

  task automatic send_write(input logic [ACT_W-1:0] act, input logic [ENTRY_W-1:0] ent,
                            input logic [SAMPLE_W-1:0] smp);
    send_item(KIND_WRITE, act, ent, smp, $urandom);
  endtask

  // Mostly table writes into the used range and time samples that move
  // forward by up to three periods; now and then a jump to a random time
  // (often behind the anchor), a small step back, a restart or an
  // unknown kind.
  task automatic random_item();
    int unsigned     pick;
    longint unsigned lim;
    logic [ENTRY_W-1:0] ent;
    pick = $urandom_range(99);
    if (pick < 45) begin
      ent = ($urandom_range(3) == 0) ? ENTRY_W'($urandom) : ENTRY_W'($urandom_range(cur_n - 1));
      send_write($urandom, ent, $urandom);
    end else if (pick < 88) begin
      case ($urandom_range(9))
        0:       tick = $urandom;
        1:       tick = tick - $urandom_range(1000);
        default: begin
          lim  = 3 * longint'((cur_span == '0) ? 1 : cur_span) + 1;
          tick = tick + TIME_W'($urandom % lim);
        end
      endcase
      send_time(tick);
    end else if (pick < 95) begin
      send_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_WRITE;
    in_actuator   = '0;
    in_entry      = '0;
    in_sample     = '0;
    in_time_now   = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_CYCLE_LEN;
    cfg_wdata     = '0;
    send_idle_pct = 30;
    recv_idle_pct = 73;
    cur_span      = RESET_CYCLE_LEN;
    cur_n         = RESET_ENTRIES;
    tick          = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset settings: period 5000000, 100 entries, 8 actuators
    // first time sample anchors the cycle; table must read back cleared
    send_time(32'd1000);
    // full-scale steps on actuator 0, wrap neighbors on actuator 7,
    // top entry (unused at 100 entries) on actuator 3
    send_write(3'd0, 7'd0, 16'sh7FFF);
    send_write(3'd0, 7'd1, 16'sh8000);
    send_write(3'd0, 7'd99, 16'sh8000);
    send_write(3'd7, 7'd99, 16'sh7FFF);
    send_write(3'd7, 7'd0, 16'shFFFF);
    send_write(3'd3, 7'd127, 16'sh5555);
    send_write(3'd5, 7'd42, -16'sd12345);
    // half period: exact entry, zero fraction
    send_time(32'd1000 + 32'd2_500_000);
    // next period, halfway between entries 0 and 1 (largest possible step)
    send_time(32'd1000 + 32'd5_000_000 + 32'd25_000);
    // last used entry interpolating toward entry 0
    send_time(32'd1000 + 32'd10_000_000 + 32'd4_987_500);
    // earlier than the anchor: phase stays zero
    send_time(32'd500);
    send_item(KIND_RESTART, 3'd0, 7'd0, 16'sd0, 32'd0);
    send_item(KIND_UNUSED, 3'd7, 7'd127, 16'sh7FFF, 32'hFFFF_FFFF);
    // re-anchor at the very top of the time range, then step behind it
    send_time(32'hFFFF_FFFF);
    send_time(32'd0);
    send_write(3'd2, 7'd99, 16'sh4000);
    send_time(32'hFFFF_FFFF);

    // ---- random, one block of transactions per setting
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: apply_settings(32'd997, 8'd16, 4'd8);
        1: apply_settings(32'd1, 8'd2, 4'd1);          // smallest legal values
        2: apply_settings(32'hFFFF_FFFF, 8'd128, 4'd8); // largest legal values
        3: apply_settings(32'd0, 8'd0, 4'd0);          // zeros fall back to minimums
        4: apply_settings($urandom_range(100000, 50), 8'd255, 4'd15); // clamped high
        default: apply_settings($urandom, N_W'($urandom_range(TAB_DEPTH, 1)),
                                CNT_W'($urandom_range(9, 1)));
      endcase
      // swap the stall pattern, then run with no stalls at all
      if (s == 2) begin
        send_idle_pct = 73;
        recv_idle_pct = 30;
      end else if (s == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat ((s == 0 || s == 5) ? 30 : 15) random_item();
    end

    wait_idle();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ptli_pkg.sv
hw/rtl/ptli_ram.sv
hw/rtl/ptli_div.sv
hw/rtl/periodic_table_linear_interp.sv
tb/ptli_drive_checker.sv
tb/tb_periodic_table_linear_interp.sv
